>>> hw/rtl/siq_pkg.sv
// siq_pkg: shared types and codes for the sorted insert queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package siq_pkg;

	localparam int VAL_W  = 32;
	localparam int KIND_W = 2;
	localparam int ST_W   = 2;
	localparam int OCC_W  = 5;

	// request kinds; the fourth code is reserved and ignored
	typedef enum logic [KIND_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_PUSH   = 2'd1,
		REQ_POP    = 2'd2
	} req_kind_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_POP_WAIT,
		S_FINISH
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic    latch_req;    // take the accepted item, clear the result
		logic    set_status;   // record status_code in the result
		status_t status_code;
		logic    clr_idx;      // scan index to the front
		logic    inc_idx;      // next scan position
		logic    rd_scan;      // read entry at scan index
		logic    rd_shift;     // read entry just below the shift index
		logic    rd_head;      // read the front entry
		logic    wr_tail;      // append the item at the tail, count up
		logic    start_shift;  // shift index to the tail
		logic    wr_shift;     // move the read entry one place back, shift index down
		logic    wr_ins;       // write the item at the shift index, count up
		logic    pop_take;     // take read data as result, drop the front entry
		logic    load_out;     // load the result into the output register
	} siq_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              empty;
		logic              scan_end;   // scan index reached the count
		logic              shift_end;  // shift index reached the insert position
		logic              precedes;   // read entry strictly precedes the item
		logic              out_busy;   // output register holds an untaken item
	} siq_sts_t;

endpackage

>>> hw/rtl/siq_req_if.sv
// siq_req_if / siq_res_if: valid/ready channels for requests and results.
// Depends on siq_pkg for field widths.
interface siq_req_if;
	logic                             valid;
	logic                             ready;
	logic [siq_pkg::KIND_W-1:0]       req_type;
	logic signed [siq_pkg::VAL_W-1:0] item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface siq_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [siq_pkg::VAL_W-1:0] popped_value;
	logic [siq_pkg::ST_W-1:0]         status;
	logic [siq_pkg::OCC_W-1:0]        occupancy;

	modport source (output valid, output popped_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input popped_value, input status, input occupancy,
		output ready);
endinterface

>>> hw/rtl/siq_ctrl.sv
// siq_ctrl: request sequencer for the sorted insert queue.
// Depends on siq_pkg (state, command and status types).
module siq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  siq_pkg::siq_sts_t  sts,
	output siq_pkg::siq_cmd_t  cmd
);

	siq_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= siq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			siq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_nxt     = siq_pkg::S_DECIDE;
				end
			end
			siq_pkg::S_DECIDE: begin
				case (sts.kind)
					siq_pkg::REQ_INSERT: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = siq_pkg::ST_FULL;
							state_nxt       = siq_pkg::S_FINISH;
						end else begin
							cmd.clr_idx = 1'b1;
							state_nxt   = siq_pkg::S_SCAN;
						end
					end
					siq_pkg::REQ_PUSH: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = siq_pkg::ST_FULL;
						end else begin
							cmd.wr_tail = 1'b1;
						end
						state_nxt = siq_pkg::S_FINISH;
					end
					siq_pkg::REQ_POP: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = siq_pkg::ST_EMPTY;
							state_nxt       = siq_pkg::S_FINISH;
						end else begin
							cmd.rd_head = 1'b1;
							state_nxt   = siq_pkg::S_POP_WAIT;
						end
					end
					// reserved kind: nothing changes
					default: state_nxt = siq_pkg::S_FINISH;
				endcase
			end
			// walk from the front until an entry does not precede the item
			siq_pkg::S_SCAN: begin
				if (sts.scan_end) begin
					cmd.start_shift = 1'b1;
					state_nxt       = siq_pkg::S_SHIFT_RD;
				end else begin
					cmd.rd_scan = 1'b1;
					state_nxt   = siq_pkg::S_CMP;
				end
			end
			siq_pkg::S_CMP: begin
				if (sts.precedes) begin
					cmd.inc_idx = 1'b1;
					state_nxt   = siq_pkg::S_SCAN;
				end else begin
					cmd.start_shift = 1'b1;
					state_nxt       = siq_pkg::S_SHIFT_RD;
				end
			end
			// open a gap by moving entries back from the tail
			siq_pkg::S_SHIFT_RD: begin
				if (sts.shift_end) begin
					cmd.wr_ins = 1'b1;
					state_nxt  = siq_pkg::S_FINISH;
				end else begin
					cmd.rd_shift = 1'b1;
					state_nxt    = siq_pkg::S_SHIFT_WR;
				end
			end
			siq_pkg::S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				state_nxt    = siq_pkg::S_SHIFT_RD;
			end
			siq_pkg::S_POP_WAIT: begin
				cmd.pop_take = 1'b1;
				state_nxt    = siq_pkg::S_FINISH;
			end
			siq_pkg::S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_nxt    = siq_pkg::S_IDLE;
				end
			end
			default: state_nxt = siq_pkg::S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/siq_dp.sv
// siq_dp: entry memory, head/count/index registers, compare and output register.
// Depends on siq_pkg (command and status types, field widths).
module siq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  siq_pkg::siq_cmd_t                cmd,
	output siq_pkg::siq_sts_t                sts,
	input  logic                             order_desc,
	input  logic [siq_pkg::KIND_W-1:0]       req_type,
	input  logic signed [siq_pkg::VAL_W-1:0] item_value,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [siq_pkg::VAL_W-1:0] popped_value,
	output logic [siq_pkg::ST_W-1:0]         status,
	output logic [siq_pkg::OCC_W-1:0]        occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// circular entry store, front at head_q
	logic signed [siq_pkg::VAL_W-1:0] mem [DEPTH];

	logic [AW-1:0]                    head_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    idx_q;
	logic [CW-1:0]                    shf_q;
	logic [siq_pkg::KIND_W-1:0]       kind_q;
	logic signed [siq_pkg::VAL_W-1:0] val_q;
	logic signed [siq_pkg::VAL_W-1:0] rd_data_q;
	logic signed [siq_pkg::VAL_W-1:0] res_val_q;
	logic [siq_pkg::ST_W-1:0]         res_st_q;
	logic                             out_valid_q;
	logic signed [siq_pkg::VAL_W-1:0] out_val_q;
	logic [siq_pkg::ST_W-1:0]         out_st_q;
	logic [siq_pkg::OCC_W-1:0]        out_occ_q;

	logic [CW-1:0] rd_off, wr_off;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          rd_en, wr_en;
	logic signed [siq_pkg::VAL_W-1:0] wr_data;

	// position of the entry off places behind the front
	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		begin
			sum = SW'(head) + SW'(off);
			if (sum >= SW'(DEPTH)) begin
				sum = sum - SW'(DEPTH);
			end
			wrap_addr = sum[AW-1:0];
		end
	endfunction

	// memory address selection
	always_comb begin
		rd_en  = cmd.rd_scan | cmd.rd_shift | cmd.rd_head;
		rd_off = '0;
		if (cmd.rd_scan) begin
			rd_off = idx_q;
		end else if (cmd.rd_shift) begin
			rd_off = shf_q - CW'(1);
		end
		wr_en   = cmd.wr_tail | cmd.wr_shift | cmd.wr_ins;
		wr_off  = cmd.wr_tail ? count_q : shf_q;
		wr_data = cmd.wr_shift ? rd_data_q : val_q;
		rd_addr = wrap_addr(head_q, rd_off);
		wr_addr = wrap_addr(head_q, wr_off);
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			kind_q    <= req_type;
			val_q     <= item_value;
			res_val_q <= '0;
			res_st_q  <= siq_pkg::ST_DONE;
		end else begin
			if (cmd.set_status) begin
				res_st_q <= cmd.status_code;
			end
			if (cmd.pop_take) begin
				res_val_q <= rd_data_q;
			end
		end
	end

	// scan and shift indexes
	always_ff @(posedge clk) begin
		if (cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.inc_idx) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.start_shift) begin
			shf_q <= count_q;
		end else if (cmd.wr_shift) begin
			shf_q <= shf_q - CW'(1);
		end
	end

	// list head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.wr_tail || cmd.wr_ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_take) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
			out_occ_q <= siq_pkg::OCC_W'(count_q);
		end
	end

	// status to the controller
	always_comb begin
		sts.kind      = kind_q;
		sts.full      = (count_q == CW'(DEPTH));
		sts.empty     = (count_q == '0);
		sts.scan_end  = (idx_q == count_q);
		sts.shift_end = (shf_q == idx_q);
		sts.precedes  = order_desc ? (rd_data_q > val_q) : (rd_data_q < val_q);
		sts.out_busy  = out_valid_q & ~res_ready;
	end

	assign res_valid    = out_valid_q;
	assign popped_value = out_val_q;
	assign status       = out_st_q;
	assign occupancy    = out_occ_q;

endmodule

>>> hw/rtl/sorted_insert_queue.sv
// sorted_insert_queue: bounded ordered list of signed 32-bit values.
// Depends on siq_pkg, siq_req_if/siq_res_if, siq_ctrl and siq_dp.
//
// Usage: requests arrive on the req channel (req_type, item_value), one
// result per request leaves on the res channel (popped_value, status,
// occupancy). Kinds: sorted insert (ahead of equal entries), tail push,
// pop front. A full list drops an insert or push with status full; a pop
// on an empty list reports status empty. Sort order is set by register 0
// (order_descending) on the APB port; the user must write it only while the
// queue is idle; the block does not enforce this. Timing: one request at a
// time. A push, a full or empty error and the unused kind pass the decide and
// finish states, a pop also reads the front entry, a sorted insert scans from
// the front, then shifts entries back from the tail; each scan and shift
// step is a memory read then its use. The next request can be accepted in
// the cycle after the previous result is loaded. The entry memory is a circular
// buffer, so a pop never moves entries. Reset: list empty, ascending order,
// output register empty; the memory contents are not cleared.
// Stall: a finished result sits in the output register; the next request
// is accepted while it waits, and its result waits in the finish state
// until the output register frees.
module sorted_insert_queue #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	siq_req_if.sink          req,
	siq_res_if.source        res,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	siq_pkg::siq_cmd_t cmd;
	siq_pkg::siq_sts_t sts;
	logic              order_desc_q;

	// configuration register, index taken from the word address
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			order_desc_q <= pwdata[0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {31'd0, order_desc_q};

	siq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	siq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.order_desc   (order_desc_q),
		.req_type     (req.req_type),
		.item_value   (req.item_value),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.popped_value (res.popped_value),
		.status       (res.status),
		.occupancy    (res.occupancy)
	);

	// one request in flight: acceptance closes the input until the result is queued
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in work");

	// nothing is appended to a full list
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_tail || cmd.wr_ins) |-> !sts.full)
		else $error("write into a full list");

	// a pop only removes an entry that exists
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_take |-> !sts.empty)
		else $error("entry removed from an empty list");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(res.valid && !res.ready))
		else $error("output register overwritten while stalled");

endmodule

>>> test/sorted_insert_queue_tb.sv
// sorted_insert_queue_tb: self-checking testbench for the sorted insert queue.
// Keeps a shadow list that predicts every result and checks it field by field.
// Depends on siq_pkg, siq_req_if/siq_res_if and sorted_insert_queue.
module sorted_insert_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 100;
	// unused kind, ignored by the block
	localparam logic [siq_pkg::KIND_W-1:0] REQ_RSVD = 2'd3;
	localparam logic [2:0] REG_ORDER_ADDR = 3'd0;
	localparam logic signed [siq_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [siq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic signed [siq_pkg::VAL_W-1:0] popped;
		siq_pkg::status_t                 st;
		logic [siq_pkg::OCC_W-1:0]        occ;
	} siq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request side drive
	logic                             req_valid = 1'b0;
	logic [siq_pkg::KIND_W-1:0]       req_kind = '0;
	logic signed [siq_pkg::VAL_W-1:0] req_val = '0;
	// result side drive
	logic sink_ready = 1'b1;
	int   stall_left = 0;

	// APB drive
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow state of the queue
	logic signed [siq_pkg::VAL_W-1:0] shadow_entries[$];
	bit                               desc_order = 1'b0;
	siq_result_t                      pending_results[$];

	bit idle_on = 1'b1;
	int err_count = 0;
	int quiet_cycles = 0;
	// handshakes seen mid-cycle; each completes at the next rising edge
	bit req_fire = 1'b0;
	bit res_fire = 1'b0;

	siq_req_if req_ch ();
	siq_res_if res_ch ();

	assign req_ch.valid = req_valid;
	assign req_ch.req_type = req_kind;
	assign req_ch.item_value = req_val;
	assign res_ch.ready = sink_ready;

	sorted_insert_queue #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_wait();
		return idle_on ? $urandom_range(0, 3) : 0;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (err_count < MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// true when a sits strictly ahead of b in the current order
	function automatic bit sits_ahead(input logic signed [siq_pkg::VAL_W-1:0] a,
			input logic signed [siq_pkg::VAL_W-1:0] b);
		return desc_order ? (a > b) : (a < b);
	endfunction

	// apply one accepted request to the shadow list and queue its result
	task automatic predict_list_op(input logic [siq_pkg::KIND_W-1:0] kind,
			input logic signed [siq_pkg::VAL_W-1:0] val);
		siq_result_t r;
		int pos;
		r.popped = '0;
		r.st = siq_pkg::ST_DONE;
		if (kind == siq_pkg::REQ_INSERT || kind == siq_pkg::REQ_PUSH) begin
			if (shadow_entries.size() >= LIST_DEPTH) begin
				r.st = siq_pkg::ST_FULL;
			end else if (kind == siq_pkg::REQ_PUSH) begin
				shadow_entries.push_back(val);
			end else begin
				pos = 0;
				while (pos < shadow_entries.size() && sits_ahead(shadow_entries[pos], val))
					pos++;
				shadow_entries.insert(pos, val);
			end
		end else if (kind == siq_pkg::REQ_POP) begin
			if (shadow_entries.size() == 0)
				r.st = siq_pkg::ST_EMPTY;
			else
				r.popped = shadow_entries.pop_front();
		end
		r.occ = siq_pkg::OCC_W'(shadow_entries.size());
		pending_results.push_back(r);
	endtask

	// send one item; the caller sits in the step of a rising edge
	task automatic send_req(input logic [siq_pkg::KIND_W-1:0] kind,
			input logic signed [siq_pkg::VAL_W-1:0] val);
		int gap;
		bit took;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_kind <= kind;
		req_val <= val;
		// ready is looked at mid-cycle, before the edge that takes the item
		do begin
			@(negedge clk);
			took = (req_ch.ready === 1'b1);
			@(posedge clk);
		end while (!took);
		predict_list_op(kind, val);
	endtask

	// stop sending until every queued result has come back
	task automatic pause_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_order(input bit descending);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ORDER_ADDR;
		pwdata <= {31'b0, descending};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		desc_order = descending;
		// read the register back
		@(negedge clk);
		if (prdata !== {31'b0, descending})
			flag_mismatch($sformatf("order register %0d, expected %0d",
				prdata, descending));
		@(posedge clk);
	endtask

	// extremes, a cluster of small values for ties, and full-range values
	function automatic logic signed [siq_pkg::VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// random traffic; blocks of 40 items alternate between filling and draining
	task automatic run_mixed(input int count);
		int i;
		int r;
		int add_pct;
		logic [siq_pkg::KIND_W-1:0] kind;
		for (i = 0; i < count; i++) begin
			add_pct = ((i / 40) % 2 == 0) ? 75 : 30;
			r = $urandom_range(0, 99);
			if (r < 2)
				kind = REQ_RSVD;
			else if (r < 2 + add_pct)
				kind = ($urandom_range(0, 9) < 7) ? siq_pkg::REQ_INSERT : siq_pkg::REQ_PUSH;
			else
				kind = siq_pkg::REQ_POP;
			send_req(kind, pick_value());
		end
	endtask

	// edge cases: empty pop, extremes, ties, tail push, unused kind, full list
	task automatic test_directed();
		int i;
		send_req(siq_pkg::REQ_POP, 32'sd5);
		send_req(siq_pkg::REQ_INSERT, VAL_MIN);
		send_req(siq_pkg::REQ_INSERT, VAL_MAX);
		send_req(siq_pkg::REQ_INSERT, 32'sd0);
		send_req(siq_pkg::REQ_INSERT, -32'sd1);
		send_req(siq_pkg::REQ_INSERT, 32'sd1);
		send_req(siq_pkg::REQ_INSERT, 32'sd0);
		send_req(siq_pkg::REQ_PUSH, VAL_MIN);
		send_req(REQ_RSVD, VAL_MAX);
		for (i = 0; i < 9; i++)
			send_req(siq_pkg::REQ_PUSH, pick_value());
		send_req(siq_pkg::REQ_INSERT, 32'sd3);
		send_req(siq_pkg::REQ_PUSH, 32'sd4);
		send_req(REQ_RSVD, 32'sd0);
		for (i = 0; i < 3; i++)
			send_req(siq_pkg::REQ_POP, pick_value());
	endtask

	task automatic test_mixed_ascending();
		pause_until_drained();
		write_order(1'b0);
		run_mixed(350);
	endtask

	// descending order, with a full drain halfway through
	task automatic test_mixed_descending();
		pause_until_drained();
		write_order(1'b1);
		run_mixed(175);
		pause_until_drained();
		run_mixed(175);
	endtask

	// back to back on both sides
	task automatic test_no_gaps();
		pause_until_drained();
		idle_on = 1'b0;
		write_order(1'b0);
		run_mixed(350);
		idle_on = 1'b1;
	endtask

	task automatic test_descending_again();
		pause_until_drained();
		write_order(1'b1);
		run_mixed(350);
	endtask

	// result side: random stall after each taken item
	always @(posedge clk) begin : sink_side
		int hold;
		if (res_fire) begin
			hold = draw_wait();
			stall_left <= hold;
			sink_ready <= (hold == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= (stall_left == 1);
		end
	end

	// mid-cycle: note the handshakes of the coming edge and check each result
	// that it takes against the oldest prediction
	always @(negedge clk) begin : result_check
		siq_result_t want;
		req_fire = (req_ch.valid === 1'b1 && req_ch.ready === 1'b1);
		res_fire = (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1);
		if (res_fire) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (res_ch.popped_value !== want.popped)
					flag_mismatch($sformatf("popped_value %0d, expected %0d",
						res_ch.popped_value, want.popped));
				if (res_ch.status !== want.st)
					flag_mismatch($sformatf("status %0d, expected %0d",
						res_ch.status, want.st));
				if (res_ch.occupancy !== want.occ)
					flag_mismatch($sformatf("occupancy %0d, expected %0d",
						res_ch.occupancy, want.occ));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (req_fire || res_fire || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mixed_ascending();
		test_mixed_descending();
		test_no_gaps();
		test_descending_again();
		pause_until_drained();
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/siq_pkg.sv
hw/rtl/siq_req_if.sv
hw/rtl/siq_ctrl.sv
hw/rtl/siq_dp.sv
hw/rtl/sorted_insert_queue.sv
test/sorted_insert_queue_tb.sv
